// ===== rtl/abl_pkg.sv =====
`timescale 1ns / 1ps

package abl_pkg;

    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int CH_N   = PIX_W / CH_W;
    localparam int DIM_W  = 12;
    localparam int SUM_W  = 12;
    localparam int WIN_N  = 9;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
    localparam logic [DIM_W-1:0] ROW_SAT      = '1;

    // register map, index is paddr[2]
    localparam int  APB_AW = 3;
    localparam int  APB_DW = 32;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // floor(x / 10) == (x * 52429) >> 19 for x below 43690
    localparam int                 DIV10_MUL_W = 16;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(52429);
    localparam int                 DIV10_SHIFT = 19;
    localparam int                 QUOT_W      = SUM_W + DIV10_MUL_W - DIV10_SHIFT;
    localparam logic [CH_W-1:0]    CH_MAX      = '1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [WIN_N-1:0] t_win;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_border;

    typedef struct packed {
        logic    emit;
        logic    last;
        t_border border;
    } t_ctl;

endpackage

// ===== rtl/abl_line_window.sv =====
`timescale 1ns / 1ps

module abl_line_window #(
    parameter int MAX_WIDTH = abl_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_acc,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  abl_pkg::t_pix                 i_pix,
    input  abl_pkg::t_ctl                 i_ctl,
    output logic                          o_valid,
    output abl_pkg::t_ctl                 o_ctl,
    output abl_pkg::t_win                 o_win
);
    import abl_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // one entry per column: upper half is two rows up, lower half one row up
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd;

    logic               r1_valid;
    logic [CW-1:0]      r1_col;
    t_pix               r1_pix;
    t_ctl               r1_ctl;

    logic               r2_valid;
    t_ctl               r2_ctl;
    t_win               r_win;

    logic [2*PIX_W-1:0] rd_eff;
    logic [2*PIX_W-1:0] wr_data;
    logic               wr_en;
    t_pix               top_pix;
    t_pix               mid_pix;

    assign rd_eff  = r_fwd ? r_fwd_data : r_rd;
    assign top_pix = rd_eff[2*PIX_W-1:PIX_W];
    assign mid_pix = rd_eff[PIX_W-1:0];
    assign wr_data = {mid_pix, r1_pix};
    assign wr_en   = i_adv && r1_valid;

    // memory: read at accept, written back from the stage 1 registers on the next advance
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd <= r_line_mem[i_col];
        end
        if (wr_en) begin
            r_line_mem[r1_col] <= wr_data;
        end
    end

    // same column read while the previous beat writes it (one pixel per row)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_adv) begin
            r_fwd <= i_acc && wr_en && (i_col == r1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_acc;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r1_col <= i_col;
            r1_pix <= i_pix;
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (wr_en) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= top_pix;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid_pix;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r1_pix;
        end
    end

    assign o_valid = r2_valid;
    assign o_ctl   = r2_ctl;
    assign o_win   = r_win;

endmodule

// ===== rtl/abl_blur_math.sv =====
`timescale 1ns / 1ps

module abl_blur_math (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  abl_pkg::t_ctl  i_ctl,
    input  abl_pkg::t_win  i_win,
    output logic           o_valid,
    output logic           o_last,
    output abl_pkg::t_pix  o_pix
);
    import abl_pkg::*;

    logic                    r3_valid;
    t_ctl                    r3_ctl;
    logic [CH_N-1:0][SUM_W-1:0] r3_sum;
    logic [CH_N-1:0][SUM_W-1:0] n_sum;

    // weighted sum per channel, centre weight 8, outside pixels dropped
    always_comb begin
        logic [2:0]      row_ok;
        logic [2:0]      col_ok;
        logic [CH_W-1:0] c;
        row_ok = {i_ctl.border.bottom, 1'b1, i_ctl.border.top};
        col_ok = {i_ctl.border.right, 1'b1, i_ctl.border.left};
        n_sum  = '0;
        for (int ch = 0; ch < CH_N; ch++) begin
            for (int k = 0; k < WIN_N; k++) begin
                c = i_win[k][ch*CH_W +: CH_W];
                if (row_ok[k/3] && col_ok[k%3]) begin
                    if (k == 4) begin
                        n_sum[ch] = n_sum[ch] + {1'b0, c, 3'b000};
                    end else begin
                        n_sum[ch] = n_sum[ch] + SUM_W'(c);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_ctl <= i_ctl;
            r3_sum <= n_sum;
        end
    end

    // divide by ten through the reciprocal, then saturate
    always_comb begin
        logic [SUM_W+DIV10_MUL_W-1:0] prod;
        logic [QUOT_W-1:0]            quot;
        o_pix = '0;
        for (int ch = 0; ch < CH_N; ch++) begin
            prod = r3_sum[ch] * DIV10_MUL;
            quot = prod[DIV10_SHIFT +: QUOT_W];
            o_pix[ch*CH_W +: CH_W] = (quot > QUOT_W'(CH_MAX)) ? CH_MAX : quot[CH_W-1:0];
        end
    end

    assign o_valid = r3_valid && r3_ctl.emit;
    assign o_last  = r3_ctl.last;

endmodule

// ===== rtl/argb_blur_3x3_core.sv =====
// an accepted beat moves through the stage 1 registers, the window and the sum register into the output register
// results trail the input by image_width + 1 beats; flush beats drain the last row
// throughput: one beat per cycle unless stalled, set by the line memory's one read and write port
// reset: synchronous active low, clears position counters, window and valid flags
// reset leaves image_width = 640 and image_height = 480; line memory content is not cleared
`timescale 1ns / 1ps

module argb_blur_3x3_core #(
    parameter int MAX_WIDTH  = abl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abl_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [abl_pkg::PIX_W-1:0]   i_pixel_in,
    // result stream
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [abl_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                        o_frame_last,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abl_pkg::APB_AW-1:0]  paddr,
    input  logic [abl_pkg::APB_DW-1:0]  pwdata,
    output logic [abl_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import abl_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int KW   = (CW > DIM_W) ? CW : DIM_W;
    localparam int WCAP = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
    localparam int HCAP = (MAX_HEIGHT < 4095) ? MAX_HEIGHT : 4095;

    // configuration
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             cfg_wr;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // input and output positions
    logic [CW-1:0]    r_in_col,  n_in_col;
    logic [DIM_W-1:0] r_in_row,  n_in_row;
    logic [CW-1:0]    r_out_col, n_out_col;
    logic [DIM_W-1:0] r_out_row, n_out_row;

    // handshake
    logic adv;
    logic acc;

    // front stage
    t_pix front_pix;
    t_ctl front_ctl;
    logic in_col_end;
    logic out_col_end;
    logic out_row_end;

    // stage outputs
    logic lw_valid;
    t_ctl lw_ctl;
    t_win lw_win;
    logic m_valid;
    logic m_last;
    t_pix m_pix;

    // output register
    logic r_out_valid;
    t_pix r_pixel_out;
    logic r_frame_last;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IMAGE_WIDTH) begin
                r_width <= pwdata[DIM_W-1:0];
            end else begin
                r_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? APB_DW'(r_height) : APB_DW'(r_width);

    // zero acts as one; oversize width stops at the line memory depth, oversize height at MAX_HEIGHT
    assign w_eff = (r_width == '0) ? DIM_W'(1) :
                   ((r_width > DIM_W'(WCAP)) ? DIM_W'(WCAP) : r_width);
    assign h_eff = (r_height == '0) ? DIM_W'(1) :
                   ((r_height > DIM_W'(HCAP)) ? DIM_W'(HCAP) : r_height);

    // ---------------- handshake ----------------
    // whole pipe moves together; it only halts when a finished beat is held
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;
    assign acc        = i_in_valid && adv;

    // ---------------- front stage ----------------
    assign in_col_end  = (KW'(r_in_col)  == KW'(w_eff) - KW'(1));
    assign out_col_end = (KW'(r_out_col) == KW'(w_eff) - KW'(1));
    assign out_row_end = (r_out_row == h_eff - DIM_W'(1));

    always_comb begin
        // flush beats and beats past the last row feed zeros
        if (i_mode == MODE_FLUSH || r_in_row >= h_eff) begin
            front_pix = '0;
        end else begin
            front_pix = i_pixel_in;
        end
        // a result exists once image_width + 1 beats are in
        front_ctl.emit          = (r_in_row >= DIM_W'(2)) ||
                                  (r_in_row == DIM_W'(1) && r_in_col != '0);
        front_ctl.last          = front_ctl.emit && out_col_end && out_row_end;
        front_ctl.border.top    = (r_out_row != '0);
        front_ctl.border.bottom = !out_row_end;
        front_ctl.border.left   = (r_out_col != '0);
        front_ctl.border.right  = !out_col_end;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr) begin
            // a register write abandons the frame in progress
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (acc) begin
            if (in_col_end) begin
                n_in_col = '0;
                if (r_in_row != ROW_SAT) begin
                    n_in_row = r_in_row + DIM_W'(1);
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (front_ctl.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (front_ctl.emit) begin
                if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + DIM_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---------------- line memory and window ----------------
    abl_line_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_acc   (acc),
        .i_col   (r_in_col),
        .i_pix   (front_pix),
        .i_ctl   (front_ctl),
        .o_valid (lw_valid),
        .o_ctl   (lw_ctl),
        .o_win   (lw_win)
    );

    // ---------------- weighted sum and divide ----------------
    abl_blur_math u_blur_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (lw_valid),
        .i_ctl   (lw_ctl),
        .i_win   (lw_win),
        .o_valid (m_valid),
        .o_last  (m_last),
        .o_pix   (m_pix)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pixel_out  <= m_pix;
            r_frame_last <= m_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;

    // ---------------- assertions ----------------
    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_in_col) < KW'(w_eff))
        else $error("input column beyond image width");

    a_out_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (KW'(r_out_col) < KW'(w_eff)) && (r_out_row < h_eff))
        else $error("output position outside frame");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && front_ctl.last && !cfg_wr) |=>
            (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("positions not cleared after last beat of frame");

endmodule
